>>> rtl/per_class_box_nms_assert.svh
// ----------------------------------------------------------------------------
// per_class_box_nms_assert.svh
// Assertion macros used by the box suppression RTL.
// ----------------------------------------------------------------------------
`ifndef PER_CLASS_BOX_NMS_ASSERT_SVH
`define PER_CLASS_BOX_NMS_ASSERT_SVH

// check cons in the same cycle as ante
`define PCBN_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("per_class_box_nms assertion failed");

// check cons in the cycle after ante
`define PCBN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("per_class_box_nms assertion failed");

`endif

>>> rtl/pcbn_pkg.sv
// ----------------------------------------------------------------------------
// pcbn_pkg
// Shared constants and types for the per-class box suppression block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcbn_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int CLASS_BITS     = 3;
   localparam int IDX_W          = $clog2(MAX_CANDIDATES);
   localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
   localparam logic [15:0] THRESHOLD_RESET = 16'd29491;

   typedef struct packed {
      logic [15:0] height;
      logic [15:0] width;
      logic [15:0] cy;
      logic [15:0] cx;
   } box_type;

   typedef struct packed {
      logic signed [15:0]    angle;
      logic [CLASS_BITS-1:0] cls;
      logic [15:0]           score;
   } attr_type;

   typedef struct packed {
      logic             data_we;
      logic [IDX_W-1:0] data_waddr;
      box_type          box_wd;
      attr_type         attr_wd;
      logic [IDX_W-1:0] data_raddr;
      logic             rank_we;
      logic [IDX_W-1:0] rank_waddr;
      logic [IDX_W-1:0] rank_wd;
      logic [IDX_W-1:0] rank_raddr;
   } store_ctl_type;

   typedef struct packed {
      box_type  box;
      attr_type attr;
      logic     none_kept;
      logic     overflowed;
      logic     last_result;
   } result_type;

endpackage

>>> rtl/pcbn_store.sv
// ----------------------------------------------------------------------------
// pcbn_store
// Candidate box, attribute and rank memories with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcbn_store (
   input  logic                           clock,
   input  pcbn_pkg::store_ctl_type        ctl,
   output pcbn_pkg::box_type              box_q,
   output pcbn_pkg::attr_type             attr_q,
   output logic [pcbn_pkg::IDX_W-1:0]     rank_q
);

   pcbn_pkg::box_type          box_mem  [pcbn_pkg::MAX_CANDIDATES];
   pcbn_pkg::attr_type         attr_mem [pcbn_pkg::MAX_CANDIDATES];
   logic [pcbn_pkg::IDX_W-1:0] rank_mem [pcbn_pkg::MAX_CANDIDATES];

   always_ff @(posedge clock) begin
      if (ctl.data_we) begin
         box_mem[ctl.data_waddr]  <= ctl.box_wd;
         attr_mem[ctl.data_waddr] <= ctl.attr_wd;
      end
      box_q  <= box_mem[ctl.data_raddr];
      attr_q <= attr_mem[ctl.data_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.rank_we) begin
         rank_mem[ctl.rank_waddr] <= ctl.rank_wd;
      end
      rank_q <= rank_mem[ctl.rank_raddr];
   end

endmodule

>>> rtl/per_class_box_nms.sv
// ----------------------------------------------------------------------------
// per_class_box_nms
// Greedy per-class non-maximum suppression over a set of loaded boxes.
// ----------------------------------------------------------------------------
// Loads take one cycle each while req_stall is low. The request with
// final_item closes the set; the block then stalls requests while it ranks
// the N held boxes by falling score (one score compare at a time through a
// single memory read port), runs the pairwise IoU pass through one shared
// 18x18 multiplier (one same-class pair at a time) and emits the kept boxes,
// which output stalls can hold. Loading reopens after the final response is
// placed in the output register.
`timescale 1ns / 1ps
`include "per_class_box_nms_assert.svh"

module per_class_box_nms (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [15:0]                         csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_center_x,
   input  logic [15:0]                         req_center_y,
   input  logic [15:0]                         req_box_width,
   input  logic [15:0]                         req_box_height,
   input  logic [15:0]                         req_score,
   input  logic [pcbn_pkg::CLASS_BITS-1:0]     req_class_index,
   input  logic signed [15:0]                  req_angle,
   input  logic                                req_final_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [15:0]                         rsp_out_center_x,
   output logic [15:0]                         rsp_out_center_y,
   output logic [15:0]                         rsp_out_width,
   output logic [15:0]                         rsp_out_height,
   output logic [15:0]                         rsp_out_score,
   output logic [pcbn_pkg::CLASS_BITS-1:0]     rsp_out_class,
   output logic signed [15:0]                  rsp_out_angle,
   output logic                                rsp_none_kept,
   output logic                                rsp_overflowed,
   output logic                                rsp_last_result
);

   localparam logic [4:0] ST_LOAD = 5'd0;
   localparam logic [4:0] ST_R_A  = 5'd1;
   localparam logic [4:0] ST_R_B  = 5'd2;
   localparam logic [4:0] ST_R_C  = 5'd3;
   localparam logic [4:0] ST_R_D  = 5'd4;
   localparam logic [4:0] ST_R_E  = 5'd5;
   localparam logic [4:0] ST_S_A  = 5'd6;
   localparam logic [4:0] ST_S_B  = 5'd7;
   localparam logic [4:0] ST_S_C  = 5'd8;
   localparam logic [4:0] ST_S_D  = 5'd9;
   localparam logic [4:0] ST_S_E  = 5'd10;
   localparam logic [4:0] ST_S_F  = 5'd11;
   localparam logic [4:0] ST_S_G  = 5'd12;
   localparam logic [4:0] ST_S_H  = 5'd13;
   localparam logic [4:0] ST_S_I  = 5'd14;
   localparam logic [4:0] ST_S_J  = 5'd15;
   localparam logic [4:0] ST_S_K  = 5'd16;
   localparam logic [4:0] ST_S_L  = 5'd17;
   localparam logic [4:0] ST_S_M  = 5'd18;
   localparam logic [4:0] ST_S_NJ = 5'd19;
   localparam logic [4:0] ST_S_NI = 5'd20;
   localparam logic [4:0] ST_E_A  = 5'd21;
   localparam logic [4:0] ST_E_B  = 5'd22;
   localparam logic [4:0] ST_E_C  = 5'd23;
   localparam logic [4:0] ST_E_N  = 5'd24;
   localparam logic [4:0] ST_E_F  = 5'd25;

   localparam int IW = pcbn_pkg::IDX_W;
   localparam int CW = pcbn_pkg::CNT_W;
   localparam int MC = pcbn_pkg::MAX_CANDIDATES;

   function automatic logic [16:0] span_overlap(input logic [15:0] c1, input logic [15:0] s1,
                                                input logic [15:0] c2, input logic [15:0] s2);
      logic signed [18:0] lo1, hi1, lo2, hi2, lo, hi, d;
      lo1 = $signed({2'b00, c1, 1'b0}) - $signed({3'b000, s1});
      hi1 = $signed({2'b00, c1, 1'b0}) + $signed({3'b000, s1});
      lo2 = $signed({2'b00, c2, 1'b0}) - $signed({3'b000, s2});
      hi2 = $signed({2'b00, c2, 1'b0}) + $signed({3'b000, s2});
      lo  = (lo1 > lo2) ? lo1 : lo2;
      hi  = (hi1 < hi2) ? hi1 : hi2;
      d   = hi - lo;
      span_overlap = (hi > lo) ? d[16:0] : 17'd0;
   endfunction

   logic [4:0]          state_ff, state_in;
   logic [15:0]         thr_ff, thr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [MC-1:0]       sup_ff, sup_in;
   logic [CW-1:0]       i_ff, i_in, j_ff, j_in, k_ff, k_in, pos_ff, pos_in;
   logic [15:0]         skey_ff, skey_in;
   logic [IW-1:0]       a_ff, a_in, b_ff, b_in;
   pcbn_pkg::box_type   abox_ff, abox_in, bbox_ff, bbox_in;
   logic [pcbn_pkg::CLASS_BITS-1:0] acls_ff, acls_in;
   logic [16:0]         iw_ff, iw_in, ih_ff, ih_in;
   logic [33:0]         inter_ff, inter_in;
   logic [34:0]         area_ff, area_in, uni_ff, uni_in;
   logic [33:0]         plo_ff, plo_in;
   pcbn_pkg::result_type pend_ff, pend_in, out_ff, out_in;
   logic                pend_v_ff, pend_v_in, out_v_ff, out_v_in;

   pcbn_pkg::store_ctl_type ctl;
   pcbn_pkg::box_type       box_q;
   pcbn_pkg::attr_type      attr_q;
   logic [IW-1:0]           rank_q;

   logic [17:0]  mul_a, mul_b;
   logic [35:0]  mul_p;
   logic [51:0]  lhs, rhs;
   logic         slot_free, req_take;
   pcbn_pkg::result_type fresh;

   pcbn_store u_store (
      .clock  (clock),
      .ctl    (ctl),
      .box_q  (box_q),
      .attr_q (attr_q),
      .rank_q (rank_q)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !out_v_ff || !rsp_stall;

   // shared multiplier operand select
   always_comb begin
      mul_a = 18'd0;
      mul_b = 18'd0;
      case (state_ff)
         ST_S_H: begin
            mul_a = {1'b0, iw_ff};
            mul_b = {1'b0, ih_ff};
         end
         ST_S_I: begin
            mul_a = {1'b0, abox_ff.width, 1'b0};
            mul_b = {1'b0, abox_ff.height, 1'b0};
         end
         ST_S_J: begin
            mul_a = {1'b0, bbox_ff.width, 1'b0};
            mul_b = {1'b0, bbox_ff.height, 1'b0};
         end
         ST_S_L: begin
            mul_a = {2'b00, thr_ff};
            mul_b = uni_ff[17:0];
         end
         ST_S_M: begin
            mul_a = {2'b00, thr_ff};
            mul_b = {1'b0, uni_ff[34:18]};
         end
         default: begin
            mul_a = 18'd0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;
   assign lhs   = {2'b00, inter_ff, 16'd0};
   assign rhs   = {mul_p[33:0], 18'd0} + {18'd0, plo_ff};

   always_comb begin
      fresh             = '0;
      fresh.box         = box_q;
      fresh.attr        = attr_q;
      fresh.overflowed  = ovf_ff;
   end

   always_comb begin
      state_in  = state_ff;
      thr_in    = csr_write_enable ? csr_write_data : thr_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      sup_in    = sup_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      skey_in   = skey_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      abox_in   = abox_ff;
      bbox_in   = bbox_ff;
      acls_in   = acls_ff;
      iw_in     = iw_ff;
      ih_in     = ih_ff;
      inter_in  = inter_ff;
      area_in   = area_ff;
      uni_in    = uni_ff;
      plo_in    = plo_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && rsp_stall;

      ctl              = '0;
      ctl.data_waddr   = cnt_ff[IW-1:0];
      ctl.box_wd       = {req_box_height, req_box_width, req_center_y, req_center_x};
      ctl.attr_wd      = {req_angle, req_class_index, req_score};
      ctl.data_raddr   = a_ff;
      ctl.rank_waddr   = pos_ff[IW-1:0];
      ctl.rank_wd      = k_ff[IW-1:0];
      ctl.rank_raddr   = i_ff[IW-1:0];

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (cnt_ff < CW'(MC)) begin
                  ctl.data_we = 1'b1;
                  cnt_in      = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_final_item) begin
                  i_in   = '0;
                  k_in   = '0;
                  pos_in = '0;
                  state_in = (cnt_in == '0) ? ST_E_F : ST_R_A;
               end
            end
         end
         ST_R_A: begin
            ctl.data_raddr = k_ff[IW-1:0];
            state_in = ST_R_B;
         end
         ST_R_B: begin
            skey_in  = attr_q.score;
            j_in     = '0;
            state_in = ST_R_C;
         end
         ST_R_C: begin
            ctl.data_raddr = j_ff[IW-1:0];
            state_in = ST_R_D;
         end
         ST_R_D: begin
            if ((attr_q.score > skey_ff) || ((attr_q.score == skey_ff) && (j_ff < k_ff))) begin
               pos_in = pos_ff + 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = (j_in == cnt_ff) ? ST_R_E : ST_R_C;
         end
         ST_R_E: begin
            ctl.rank_we = 1'b1;
            pos_in      = '0;
            k_in        = k_ff + 1'b1;
            state_in    = (k_in == cnt_ff) ? ST_S_A : ST_R_A;
         end
         ST_S_A: begin
            ctl.rank_raddr = i_ff[IW-1:0];
            state_in = ST_S_B;
         end
         ST_S_B: begin
            a_in = rank_q;
            ctl.data_raddr = rank_q;
            state_in = sup_ff[rank_q] ? ST_S_NI : ST_S_C;
         end
         ST_S_C: begin
            abox_in  = box_q;
            acls_in  = attr_q.cls;
            j_in     = i_ff + 1'b1;
            state_in = (j_in >= cnt_ff) ? ST_S_NI : ST_S_D;
         end
         ST_S_D: begin
            ctl.rank_raddr = j_ff[IW-1:0];
            state_in = ST_S_E;
         end
         ST_S_E: begin
            b_in = rank_q;
            ctl.data_raddr = rank_q;
            state_in = sup_ff[rank_q] ? ST_S_NJ : ST_S_F;
         end
         ST_S_F: begin
            bbox_in  = box_q;
            state_in = (attr_q.cls != acls_ff) ? ST_S_NJ : ST_S_G;
         end
         ST_S_G: begin
            iw_in    = span_overlap(abox_ff.cx, abox_ff.width, bbox_ff.cx, bbox_ff.width);
            ih_in    = span_overlap(abox_ff.cy, abox_ff.height, bbox_ff.cy, bbox_ff.height);
            state_in = ST_S_H;
         end
         ST_S_H: begin
            inter_in = mul_p[33:0];
            state_in = ST_S_I;
         end
         ST_S_I: begin
            area_in  = {1'b0, mul_p[33:0]};
            state_in = ST_S_J;
         end
         ST_S_J: begin
            area_in  = area_ff + {1'b0, mul_p[33:0]};
            state_in = ST_S_K;
         end
         ST_S_K: begin
            uni_in   = area_ff - {1'b0, inter_ff};
            state_in = ST_S_L;
         end
         ST_S_L: begin
            plo_in   = mul_p[33:0];
            state_in = ST_S_M;
         end
         ST_S_M: begin
            if ((uni_ff != '0) && (lhs > rhs)) begin
               sup_in[b_ff] = 1'b1;
            end
            state_in = ST_S_NJ;
         end
         ST_S_NJ: begin
            j_in     = j_ff + 1'b1;
            state_in = (j_in == cnt_ff) ? ST_S_NI : ST_S_D;
         end
         ST_S_NI: begin
            i_in = i_ff + 1'b1;
            if (i_in == cnt_ff) begin
               i_in     = '0;
               state_in = ST_E_A;
            end else begin
               state_in = ST_S_A;
            end
         end
         ST_E_A: begin
            ctl.rank_raddr = i_ff[IW-1:0];
            state_in = ST_E_B;
         end
         ST_E_B: begin
            a_in = rank_q;
            ctl.data_raddr = rank_q;
            state_in = sup_ff[rank_q] ? ST_E_N : ST_E_C;
         end
         ST_E_C: begin
            // hold until the previous kept box can move to the output
            if (!pend_v_ff || slot_free) begin
               if (pend_v_ff) begin
                  out_in   = pend_ff;
                  out_v_in = 1'b1;
               end
               pend_in   = fresh;
               pend_v_in = 1'b1;
               state_in  = ST_E_N;
            end
         end
         ST_E_N: begin
            i_in     = i_ff + 1'b1;
            state_in = (i_in == cnt_ff) ? ST_E_F : ST_E_A;
         end
         ST_E_F: begin
            if (slot_free) begin
               if (pend_v_ff) begin
                  out_in = pend_ff;
               end else begin
                  out_in           = '0;
                  out_in.none_kept = 1'b1;
                  out_in.overflowed = ovf_ff;
               end
               out_in.last_result = 1'b1;
               out_v_in  = 1'b1;
               pend_v_in = 1'b0;
               cnt_in    = '0;
               ovf_in    = 1'b0;
               sup_in    = '0;
               state_in  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         thr_ff    <= pcbn_pkg::THRESHOLD_RESET;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         sup_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         thr_ff    <= thr_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         sup_ff    <= sup_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      pos_ff   <= pos_in;
      skey_ff  <= skey_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      abox_ff  <= abox_in;
      bbox_ff  <= bbox_in;
      acls_ff  <= acls_in;
      iw_ff    <= iw_in;
      ih_ff    <= ih_in;
      inter_ff <= inter_in;
      area_ff  <= area_in;
      uni_ff   <= uni_in;
      plo_ff   <= plo_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_out_center_x = out_ff.box.cx;
   assign rsp_out_center_y = out_ff.box.cy;
   assign rsp_out_width    = out_ff.box.width;
   assign rsp_out_height   = out_ff.box.height;
   assign rsp_out_score    = out_ff.attr.score;
   assign rsp_out_class    = out_ff.attr.cls;
   assign rsp_out_angle    = out_ff.attr.angle;
   assign rsp_none_kept    = out_ff.none_kept;
   assign rsp_overflowed   = out_ff.overflowed;
   assign rsp_last_result  = out_ff.last_result;

   `PCBN_ASSERT_IMPL(a_count_bound, 1'b1, cnt_ff <= CW'(MC))
   `PCBN_ASSERT_IMPL(a_empty_is_last, out_v_ff && out_ff.none_kept, out_ff.last_result)
   `PCBN_ASSERT_NEXT(a_set_cleared, (state_ff == ST_E_F) && slot_free,
                     (cnt_ff == '0) && (sup_ff == '0) && !ovf_ff && (state_ff == ST_LOAD))
   `PCBN_ASSERT_IMPL(a_pass_in_range, (state_ff == ST_S_D) || (state_ff == ST_E_A),
                     (j_ff < cnt_ff) || (state_ff == ST_E_A))

endmodule

>>> tb/sv/per_class_box_nms_test.sv
// ----------------------------------------------------------------------------
// per_class_box_nms_test
// Streams candidate sets into the suppression block under random request
// bursts and response stalls. A software copy of the ranking and per-class
// IoU pass predicts the kept boxes, and each response is checked field by
// field in order. The overlap threshold is changed between sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_class_box_nms_test;

   typedef struct packed {
      logic [15:0]                     cx;
      logic [15:0]                     cy;
      logic [15:0]                     w;
      logic [15:0]                     h;
      logic [15:0]                     score;
      logic [pcbn_pkg::CLASS_BITS-1:0] cls;
      logic [15:0]                     angle;
      logic                            last;
   } cand_type;

   typedef struct packed {
      cand_type box;
      logic     none_kept;
      logic     overflowed;
      logic     last_result;
   } kept_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [15:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_center_x = '0, req_center_y = '0, req_box_width = '0;
   logic [15:0] req_box_height = '0, req_score = '0;
   logic [pcbn_pkg::CLASS_BITS-1:0] req_class_index = '0;
   logic signed [15:0] req_angle = '0;
   logic req_final_item = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [15:0] rsp_out_center_x, rsp_out_center_y, rsp_out_width, rsp_out_height;
   logic [15:0] rsp_out_score;
   logic [pcbn_pkg::CLASS_BITS-1:0] rsp_out_class;
   logic signed [15:0] rsp_out_angle;
   logic rsp_none_kept, rsp_overflowed, rsp_last_result;

   per_class_box_nms dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   cand_type pending_requests[$];
   kept_type kept_boxes[$];
   int       errors = 0;
   int       queued = 0;
   logic [15:0] nms_threshold = pcbn_pkg::THRESHOLD_RESET;

   cand_type held[pcbn_pkg::MAX_CANDIDATES];
   int       held_count = 0;
   bit       held_dropped = 0;

   function automatic longint span_overlap(longint c1, longint s1, longint c2, longint s2);
      longint lo, hi;
      lo = (2 * c1 - s1) > (2 * c2 - s2) ? (2 * c1 - s1) : (2 * c2 - s2);
      hi = (2 * c1 + s1) < (2 * c2 + s2) ? (2 * c1 + s1) : (2 * c2 + s2);
      return hi > lo ? hi - lo : 0;
   endfunction

   function automatic bit overlap_exceeds(cand_type a, cand_type b, logic [15:0] thr);
      longint inter, uni;
      inter = span_overlap(a.cx, a.w, b.cx, b.w) * span_overlap(a.cy, a.h, b.cy, b.h);
      uni = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h) - inter;
      if (uni <= 0) return 0;
      return (inter << 16) > longint'(thr) * uni;
   endfunction

   task automatic predict_request(cand_type c);
      int rank[pcbn_pkg::MAX_CANDIDATES];
      bit gone[pcbn_pkg::MAX_CANDIDATES];
      int j, emitted;
      kept_type r;
      if (held_count < pcbn_pkg::MAX_CANDIDATES) begin
         held[held_count] = c;
         held_count++;
      end else begin
         held_dropped = 1;
      end
      if (!c.last) return;
      for (int k = 0; k < held_count; k++) begin
         j = k;
         while (j > 0 && held[rank[j-1]].score < held[k].score) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = k;
         gone[k] = 0;
      end
      for (int i = 0; i < held_count; i++) begin
         if (gone[rank[i]]) continue;
         for (int m = i + 1; m < held_count; m++) begin
            if (gone[rank[m]] || held[rank[m]].cls != held[rank[i]].cls) continue;
            if (overlap_exceeds(held[rank[i]], held[rank[m]], nms_threshold))
               gone[rank[m]] = 1;
         end
      end
      emitted = 0;
      for (int i = 0; i < held_count; i++) begin
         if (gone[rank[i]]) continue;
         r = '0;
         r.box = held[rank[i]];
         r.box.last = 0;
         r.overflowed = held_dropped;
         kept_boxes.insert(kept_boxes.size(), r);
         emitted++;
      end
      if (emitted == 0) begin
         r = '0;
         r.none_kept = 1;
         r.overflowed = held_dropped;
         kept_boxes.insert(kept_boxes.size(), r);
      end
      kept_boxes[kept_boxes.size()-1].last_result = 1;
      held_count = 0;
      held_dropped = 0;
   endtask

   // request driver
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset && (!req_valid || !req_stall)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 0;
         end else if (pending_requests.size() > 0) begin
            cand_type c;
            c = pending_requests.pop_front();
            req_valid <= 1;
            req_center_x <= c.cx;
            req_center_y <= c.cy;
            req_box_width <= c.w;
            req_box_height <= c.h;
            req_score <= c.score;
            req_class_index <= c.cls;
            req_angle <= c.angle;
            req_final_item <= c.last;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response stall pattern
   int stall_mode = 0, stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         cand_type c;
         c = {req_center_x, req_center_y, req_box_width, req_box_height, req_score,
              req_class_index, req_angle, req_final_item};
         predict_request(c);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         kept_type e;
         if (kept_boxes.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = kept_boxes.pop_front();
            if (rsp_out_center_x !== e.box.cx) begin
               $error("out_center_x exp %0h got %0h", e.box.cx, rsp_out_center_x); errors++;
            end
            if (rsp_out_center_y !== e.box.cy) begin
               $error("out_center_y exp %0h got %0h", e.box.cy, rsp_out_center_y); errors++;
            end
            if (rsp_out_width !== e.box.w) begin
               $error("out_width exp %0h got %0h", e.box.w, rsp_out_width); errors++;
            end
            if (rsp_out_height !== e.box.h) begin
               $error("out_height exp %0h got %0h", e.box.h, rsp_out_height); errors++;
            end
            if (rsp_out_score !== e.box.score) begin
               $error("out_score exp %0h got %0h", e.box.score, rsp_out_score); errors++;
            end
            if (rsp_out_class !== e.box.cls) begin
               $error("out_class exp %0h got %0h", e.box.cls, rsp_out_class); errors++;
            end
            if (rsp_out_angle !== e.box.angle) begin
               $error("out_angle exp %0h got %0h", e.box.angle, rsp_out_angle); errors++;
            end
            if (rsp_none_kept !== e.none_kept) begin
               $error("none_kept exp %0b got %0b", e.none_kept, rsp_none_kept); errors++;
            end
            if (rsp_overflowed !== e.overflowed) begin
               $error("overflowed exp %0b got %0b", e.overflowed, rsp_overflowed); errors++;
            end
            if (rsp_last_result !== e.last_result) begin
               $error("last_result exp %0b got %0b", e.last_result, rsp_last_result); errors++;
            end
         end
      end
   end

   task automatic add_request(int cx, int cy, int w, int h, int s, int cls, int ang, int last);
      cand_type c;
      c = {16'(cx), 16'(cy), 16'(w), 16'(h), 16'(s), pcbn_pkg::CLASS_BITS'(cls),
           16'(ang), 1'(last)};
      pending_requests.insert(pending_requests.size(), c);
      queued++;
   endtask

   task automatic add_random_set(int n);
      logic [15:0] bx, by, tie;
      bx = 16'($urandom);
      by = 16'($urandom);
      tie = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_request($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, i == n - 1);
         else
            add_request(bx + $urandom_range(0, 200), by + $urandom_range(0, 200),
                        $urandom_range(0, 1500), $urandom_range(0, 1500),
                        ($urandom_range(0, 3) == 0) ? tie : 16'($urandom),
                        $urandom_range(0, 1), $urandom, i == n - 1);
      end
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_valid || kept_boxes.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] v);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= v;
      nms_threshold = v;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      // single boxes at the extremes, zero-area box
      add_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 16'h8000, 1);
      add_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7, 16'h7FFF, 1);
      // identical boxes: same class suppresses, other class keeps
      add_request(1000, 1000, 400, 400, 100, 2, 16'h1234, 0);
      add_request(1000, 1000, 400, 400, 200, 2, 16'hFEDC, 0);
      add_request(1000, 1000, 400, 400, 150, 3, 16'h0001, 1);
      // equal scores keep load order; zero-area pair
      add_request(500, 500, 100, 100, 777, 1, 16'h0, 0);
      add_request(5000, 5000, 100, 100, 777, 1, 16'h1, 0);
      add_request(9000, 9000, 0, 0, 777, 1, 16'h2, 0);
      add_request(9000, 9000, 0, 0, 777, 1, 16'h3, 1);
      // partial overlap near the default threshold
      add_request(2000, 2000, 600, 600, 9000, 4, 16'h0, 0);
      add_request(2080, 2000, 600, 600, 8000, 4, 16'h0, 0);
      add_request(2200, 2000, 600, 600, 7000, 4, 16'h0, 1);
      wait_idle();
      write_threshold(16'h0000);
      add_request(3000, 3000, 200, 200, 50, 5, 16'h0, 0);
      add_request(3190, 3000, 200, 200, 40, 5, 16'h0, 0);
      add_request(3000, 3000, 200, 200, 30, 5, 16'h0, 1);
      wait_idle();
      write_threshold(16'hFFFF);
      add_request(3000, 3000, 200, 200, 50, 5, 16'h0, 0);
      add_request(3000, 3000, 200, 200, 40, 5, 16'h0, 1);
      wait_idle();
      write_threshold(pcbn_pkg::THRESHOLD_RESET);
      // overflow: full store, then two dropped loads with the final one
      for (int i = 0; i < pcbn_pkg::MAX_CANDIDATES + 2; i++)
         add_request($urandom_range(0, 4000), $urandom_range(0, 4000),
                     $urandom_range(0, 800), $urandom_range(0, 800), $urandom_range(0, 20),
                     $urandom, $urandom, i == pcbn_pkg::MAX_CANDIDATES + 1);
      wait_idle();
      while (queued < 305) begin
         for (int s = 0; s < 8 && queued < 305; s++)
            add_random_set($urandom_range(1, 8));
         wait_idle();
         case ($urandom_range(0, 3))
            0: write_threshold(16'h0000);
            1: write_threshold(16'hFFFF);
            default: write_threshold(16'($urandom));
         endcase
      end
      // full store again plus one dropped final load
      for (int i = 0; i < pcbn_pkg::MAX_CANDIDATES + 1; i++)
         add_request($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, i == pcbn_pkg::MAX_CANDIDATES);
      wait_idle();
      repeat (100) @(posedge clock);
      if (errors == 0 && kept_boxes.size() == 0)
         $display("[per_class_box_nms] OK");
      else
         $display("[per_class_box_nms] ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("[per_class_box_nms] ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/pcbn_pkg.sv
rtl/pcbn_store.sv
rtl/per_class_box_nms.sv
tb/sv/per_class_box_nms_test.sv
